// ===== rtl/core/obuhp_pkg.sv =====
`default_nettype none
package obuhp_pkg;

   localparam int FrameCountBits = 32;

   localparam logic [2:0] StatusOk        = 3'd0;
   localparam logic [2:0] StatusReserved  = 3'd1;
   localparam logic [2:0] StatusExtMiss   = 3'd2;
   localparam logic [2:0] StatusSizeTrunc = 3'd3;
   localparam logic [2:0] StatusSizeLarge = 3'd4;
   localparam logic [2:0] StatusSeqShort  = 3'd5;

   localparam logic [3:0] ObuSeqHeader   = 4'd1;
   localparam logic [3:0] ObuFrameHeader = 4'd3;
   localparam logic [3:0] ObuTileGroup   = 4'd4;
   localparam logic [3:0] ObuFrame       = 4'd6;

   localparam logic [1:0] KindKey   = 2'd1;
   localparam logic [1:0] KindInter = 2'd2;
   localparam logic [1:0] KindIntra = 2'd3;

   typedef enum logic [47:0] {
      PH_HEADER      = 48'h1 << 0,
      PH_EXT         = 48'h1 << 1,
      PH_LEB         = 48'h1 << 2,
      PH_SKIP        = 48'h1 << 3,
      PH_RESERVED    = 48'h1 << 4,
      PH_FRAME       = 48'h1 << 5,
      SQ_DONE        = 48'h1 << 6,
      SQ_PROFILE     = 48'h1 << 7,
      SQ_STILL       = 48'h1 << 8,
      SQ_REDUCED     = 48'h1 << 9,
      SQ_LEVEL_R     = 48'h1 << 10,
      SQ_TIMING      = 48'h1 << 11,
      SQ_TICKS       = 48'h1 << 12,
      SQ_SCALE       = 48'h1 << 13,
      SQ_EQUAL       = 48'h1 << 14,
      SQ_UVLC_Z      = 48'h1 << 15,
      SQ_UVLC_V      = 48'h1 << 16,
      SQ_DMI         = 48'h1 << 17,
      SQ_BDL         = 48'h1 << 18,
      SQ_DM_REST     = 48'h1 << 19,
      SQ_IDD_FLAG    = 48'h1 << 20,
      SQ_OPCNT       = 48'h1 << 21,
      SQ_OP_IDC      = 48'h1 << 22,
      SQ_OP_LEVEL    = 48'h1 << 23,
      SQ_OP_TIER     = 48'h1 << 24,
      SQ_OP_DMFLAG   = 48'h1 << 25,
      SQ_OP_DELAYS   = 48'h1 << 26,
      SQ_OP_IDDFLAG  = 48'h1 << 27,
      SQ_OP_IDD      = 48'h1 << 28,
      SQ_WBITS       = 48'h1 << 29,
      SQ_HBITS       = 48'h1 << 30,
      SQ_WIDTH       = 48'h1 << 31,
      SQ_HEIGHT      = 48'h1 << 32,
      SQ_FRAMEID     = 48'h1 << 33,
      SQ_FRAMEID_LEN = 48'h1 << 34,
      SQ_SB3         = 48'h1 << 35,
      SQ_COMP4       = 48'h1 << 36,
      SQ_ORDER_HINT  = 48'h1 << 37,
      SQ_JNT         = 48'h1 << 38,
      SQ_SCT_CHOOSE  = 48'h1 << 39,
      SQ_SCT_FORCE   = 48'h1 << 40,
      SQ_IMV_CHOOSE  = 48'h1 << 41,
      SQ_IMV_FORCE   = 48'h1 << 42,
      SQ_OH_BITS     = 48'h1 << 43,
      SQ_SUPERRES3   = 48'h1 << 44,
      SQ_HIGHBD      = 48'h1 << 45,
      SQ_TWELVE      = 48'h1 << 46,
      SQ_MONO        = 48'h1 << 47
   } phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } item_type;

   typedef struct packed {
      phase_type  phase;
      logic [6:0] left;
      logic [5:0] ops;
   } step_type;

   function automatic logic is_seq(input phase_type ph);
      is_seq = !(ph inside {PH_HEADER, PH_EXT, PH_LEB, PH_SKIP, PH_RESERVED, PH_FRAME,
                            SQ_DONE});
   endfunction

   function automatic phase_type start_phase(input logic [3:0] t);
      if (t == ObuSeqHeader) start_phase = SQ_PROFILE;
      else if (t == ObuFrameHeader || t == ObuFrame) start_phase = PH_FRAME;
      else start_phase = PH_SKIP;
   endfunction

   // {chroma, depth}
   function automatic logic [5:0] colour_code(input logic [2:0] p, input logic hbd,
                                              input logic twelve, input logic mono);
      logic [3:0] bits;
      logic [1:0] chroma;
      bits = (p == 3'd2 && hbd && twelve) ? 4'd12 : (hbd ? 4'd10 : 4'd8);
      if (p == 3'd0 || p == 3'd2) chroma = mono ? 2'd0 : 2'd1;
      else if (p == 3'd1) chroma = 2'd3;
      else chroma = 2'd1;
      colour_code = {chroma, bits};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/obuhp_front.sv =====
`default_nettype none
module obuhp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_last_byte,
   output logic                    item_valid,
   output obuhp_pkg::item_type     item,
   input  wire logic               item_pop
);
   import obuhp_pkg::*;

   item_type   mem_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_stall  = (cnt_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = item_pop ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) mem_ff[wptr_ff] <= '{data: req_data_byte, last: req_last_byte};
   end

endmodule
`default_nettype wire

// ===== rtl/core/obuhp_back.sv =====
`default_nettype none
module obuhp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire obuhp_pkg::item_type item,
   output logic                    item_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [3:0]              rsp_obu_type,
   output logic                    rsp_is_slice,
   output logic [1:0]              rsp_picture_kind,
   output logic [16:0]             rsp_frame_width,
   output logic [16:0]             rsp_frame_height,
   output logic [3:0]              rsp_sample_bits,
   output logic [1:0]              rsp_chroma_format,
   output logic [31:0]             rsp_frames_seen
);
   import obuhp_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE   = 4'b0001,
      B_BYTE   = 4'b0010,
      B_BITS   = 4'b0100,
      B_RESULT = 4'b1000
   } bstate_type;

   bstate_type st_ff, st_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [2:0]  bit_ff, bit_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [6:0]  left_ff, left_in;
   logic [55:0] leb_ff, leb_in;
   logic [3:0]  lebcnt_ff, lebcnt_in;
   logic [31:0] pay_ff, pay_in;
   logic [5:0]  ops_ff, ops_in;
   logic [2:0]  prof_ff, prof_in;
   logic        reduced_ff, reduced_in, dm_ff, dm_in, idd_ff, idd_in, oh_ff, oh_in;
   logic        hbd_ff, hbd_in, twelve_ff, twelve_in, size_ff, size_in;
   logic        frame_ff, frame_in;
   logic [1:0]  fkind_ff, fkind_in;
   logic [5:0]  delay_ff, delay_in;
   logic [16:0] pw_ff, pw_in, ph_ff, ph_in;
   logic [5:0]  colour_ff, colour_in;
   logic [3:0]  type_ff, type_in;
   logic [1:0]  kind_ff, kind_in;
   logic [16:0] cw_ff, cw_in, ch_ff, ch_in;
   logic [3:0]  cbits_ff, cbits_in;
   logic [1:0]  cchroma_ff, cchroma_in;
   logic [FrameCountBits-1:0] count_ff, count_in;
   logic        ov_ff, ov_in;
   logic [2:0]  ostatus_ff, ostatus_in;
   logic [3:0]  otype_ff, otype_in;
   logic        oslice_ff, oslice_in;
   logic [31:0] oframes_ff, oframes_in;

   step_type    oe, ad, at;
   logic        bitv;
   logic [31:0] acc_n;
   logic [6:0]  left_n;
   logic [1:0]  ft;
   logic [2:0]  status;
   logic        ok;

   assign rsp_valid         = ov_ff;
   assign rsp_status        = ostatus_ff;
   assign rsp_obu_type      = otype_ff;
   assign rsp_is_slice      = oslice_ff;
   assign rsp_picture_kind  = kind_ff;
   assign rsp_frame_width   = cw_ff;
   assign rsp_frame_height  = ch_ff;
   assign rsp_sample_bits   = cbits_ff;
   assign rsp_chroma_format = cchroma_ff;
   assign rsp_frames_seen   = oframes_ff;

   // end of one operating point and the optional parts before it
   always_comb begin
      if (ops_ff > 6'd1) oe = '{phase: SQ_OP_IDC, left: 7'd12, ops: ops_ff - 6'd1};
      else oe = '{phase: SQ_WBITS, left: 7'd4, ops: 6'd0};
      ad = idd_ff ? '{phase: SQ_OP_IDDFLAG, left: 7'd1, ops: ops_ff} : oe;
      at = dm_ff ? '{phase: SQ_OP_DMFLAG, left: 7'd1, ops: ops_ff} : ad;
   end

   always_comb begin
      bitv   = byte_ff[bit_ff];
      acc_n  = {acc_ff[30:0], bitv};
      left_n = (left_ff != 7'd0) ? left_ff - 7'd1 : left_ff;
      ft     = byte_ff[7] ? 2'd1 : byte_ff[6:5];
      if (phase_ff == PH_RESERVED) status = StatusReserved;
      else if (phase_ff == PH_EXT) status = StatusExtMiss;
      else if (phase_ff == PH_LEB) status = StatusSizeTrunc;
      else if (size_ff && leb_ff > {24'd0, pay_ff}) status = StatusSizeLarge;
      else if (type_ff == ObuSeqHeader && (phase_ff != SQ_DONE || pay_ff < 32'd4))
         status = StatusSeqShort;
      else status = StatusOk;
      ok = (status == StatusOk);
   end

   always_comb begin
      st_in = st_ff; byte_in = byte_ff; last_in = last_ff; bit_in = bit_ff;
      phase_in = phase_ff; acc_in = acc_ff; left_in = left_ff; leb_in = leb_ff;
      lebcnt_in = lebcnt_ff; pay_in = pay_ff; ops_in = ops_ff; prof_in = prof_ff;
      reduced_in = reduced_ff; dm_in = dm_ff; idd_in = idd_ff; oh_in = oh_ff;
      hbd_in = hbd_ff; twelve_in = twelve_ff; size_in = size_ff; frame_in = frame_ff;
      fkind_in = fkind_ff; delay_in = delay_ff; pw_in = pw_ff; ph_in = ph_ff;
      colour_in = colour_ff; type_in = type_ff; kind_in = kind_ff; cw_in = cw_ff;
      ch_in = ch_ff; cbits_in = cbits_ff; cchroma_in = cchroma_ff; count_in = count_ff;
      ostatus_in = ostatus_ff; otype_in = otype_ff; oslice_in = oslice_ff;
      oframes_in = oframes_ff;
      ov_in = ov_ff && rsp_stall;
      item_pop = 1'b0;

      case (st_ff)
         B_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               byte_in  = item.data;
               last_in  = item.last;
               st_in    = B_BYTE;
            end
         end
         B_BYTE: begin
            st_in = last_ff ? B_RESULT : B_IDLE;
            if (phase_ff == PH_HEADER) begin
               type_in = byte_ff[6:3];
               if (byte_ff[0]) phase_in = PH_RESERVED;
               else begin
                  size_in = byte_ff[1];
                  if (byte_ff[2]) phase_in = PH_EXT;
                  else if (byte_ff[1]) phase_in = PH_LEB;
                  else begin
                     phase_in = start_phase(byte_ff[6:3]);
                     left_in  = 7'd3;
                     acc_in   = '0;
                  end
               end
            end else if (phase_ff == PH_EXT) begin
               if (size_ff) phase_in = PH_LEB;
               else begin
                  phase_in = start_phase(type_ff);
                  left_in  = 7'd3;
                  acc_in   = '0;
               end
            end else if (phase_ff == PH_LEB) begin
               for (int i = 0; i < 8; i++) begin
                  if (lebcnt_ff[2:0] == 3'(i)) leb_in[7*i +: 7] = leb_ff[7*i +: 7] | byte_ff[6:0];
               end
               lebcnt_in = lebcnt_ff + 4'd1;
               // the eighth size byte closes the field whatever its top bit
               if (!byte_ff[7] || lebcnt_ff >= 4'd7) begin
                  phase_in = start_phase(type_ff);
                  left_in  = 7'd3;
                  acc_in   = '0;
               end
            end else if (phase_ff != PH_RESERVED) begin
               if (pay_ff != 32'hffff_ffff) pay_in = pay_ff + 32'd1;
               if (phase_ff == PH_FRAME) begin
                  frame_in = 1'b1;
                  fkind_in = (ft == 2'd0) ? KindKey : ((ft == 2'd2) ? KindIntra : KindInter);
                  phase_in = PH_SKIP;
               end else if (is_seq(phase_ff)) begin
                  st_in  = B_BITS;
                  bit_in = 3'd7;
               end
            end
         end
         B_BITS: begin
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) st_in = last_ff ? B_RESULT : B_IDLE;
            if (is_seq(phase_ff)) begin
               acc_in  = acc_n;
               left_in = left_n;
               if (left_n == 7'd0) begin
                  acc_in = '0;
                  case (phase_ff)
                     SQ_PROFILE: begin
                        prof_in = acc_n[2:0];
                        phase_in = SQ_STILL; left_in = 7'd1;
                     end
                     SQ_STILL: begin phase_in = SQ_REDUCED; left_in = 7'd1; end
                     SQ_REDUCED: begin
                        if (acc_n != 32'd0) begin
                           reduced_in = 1'b1; phase_in = SQ_LEVEL_R; left_in = 7'd5;
                        end else begin phase_in = SQ_TIMING; left_in = 7'd1; end
                     end
                     SQ_LEVEL_R: begin phase_in = SQ_WBITS; left_in = 7'd4; end
                     SQ_TIMING: begin
                        if (acc_n != 32'd0) begin phase_in = SQ_TICKS; left_in = 7'd32; end
                        else begin phase_in = SQ_IDD_FLAG; left_in = 7'd1; end
                     end
                     SQ_TICKS: begin phase_in = SQ_SCALE; left_in = 7'd32; end
                     SQ_SCALE: begin phase_in = SQ_EQUAL; left_in = 7'd1; end
                     SQ_EQUAL: begin
                        if (acc_n != 32'd0) begin
                           delay_in = 6'd0; phase_in = SQ_UVLC_Z; left_in = 7'd1;
                        end else begin phase_in = SQ_DMI; left_in = 7'd1; end
                     end
                     SQ_UVLC_Z: begin
                        if (acc_n == 32'd0) begin
                           if (delay_ff < 6'd32) delay_in = delay_ff + 6'd1;
                           phase_in = SQ_UVLC_Z; left_in = 7'd1;
                        end else if (delay_ff == 6'd0 || delay_ff >= 6'd32) begin
                           phase_in = SQ_DMI; left_in = 7'd1;
                        end else begin
                           phase_in = SQ_UVLC_V; left_in = {1'b0, delay_ff};
                        end
                     end
                     SQ_UVLC_V: begin phase_in = SQ_DMI; left_in = 7'd1; end
                     SQ_DMI: begin
                        if (acc_n != 32'd0) begin
                           dm_in = 1'b1; phase_in = SQ_BDL; left_in = 7'd5;
                        end else begin phase_in = SQ_IDD_FLAG; left_in = 7'd1; end
                     end
                     SQ_BDL: begin
                        delay_in = {1'b0, acc_n[4:0]} + 6'd1;
                        phase_in = SQ_DM_REST; left_in = 7'd42;
                     end
                     SQ_DM_REST: begin phase_in = SQ_IDD_FLAG; left_in = 7'd1; end
                     SQ_IDD_FLAG: begin
                        if (acc_n != 32'd0) idd_in = 1'b1;
                        phase_in = SQ_OPCNT; left_in = 7'd5;
                     end
                     SQ_OPCNT: begin
                        ops_in = {1'b0, acc_n[4:0]} + 6'd1;
                        phase_in = SQ_OP_IDC; left_in = 7'd12;
                     end
                     SQ_OP_IDC: begin phase_in = SQ_OP_LEVEL; left_in = 7'd5; end
                     SQ_OP_LEVEL: begin
                        if (acc_n > 32'd7) begin phase_in = SQ_OP_TIER; left_in = 7'd1; end
                        else begin phase_in = at.phase; left_in = at.left; ops_in = at.ops; end
                     end
                     SQ_OP_TIER: begin
                        phase_in = at.phase; left_in = at.left; ops_in = at.ops;
                     end
                     SQ_OP_DMFLAG: begin
                        if (acc_n != 32'd0) begin
                           phase_in = SQ_OP_DELAYS;
                           left_in  = {delay_ff, 1'b1};
                        end else begin
                           phase_in = ad.phase; left_in = ad.left; ops_in = ad.ops;
                        end
                     end
                     SQ_OP_DELAYS: begin
                        phase_in = ad.phase; left_in = ad.left; ops_in = ad.ops;
                     end
                     SQ_OP_IDDFLAG: begin
                        if (acc_n != 32'd0) begin phase_in = SQ_OP_IDD; left_in = 7'd4; end
                        else begin phase_in = oe.phase; left_in = oe.left; ops_in = oe.ops; end
                     end
                     SQ_OP_IDD: begin
                        phase_in = oe.phase; left_in = oe.left; ops_in = oe.ops;
                     end
                     SQ_WBITS: begin
                        pw_in = {13'd0, acc_n[3:0]} + 17'd1;
                        phase_in = SQ_HBITS; left_in = 7'd4;
                     end
                     SQ_HBITS: begin
                        ph_in = {13'd0, acc_n[3:0]} + 17'd1;
                        phase_in = SQ_WIDTH; left_in = pw_ff[6:0];
                     end
                     SQ_WIDTH: begin
                        pw_in = {1'b0, acc_n[15:0]} + 17'd1;
                        phase_in = SQ_HEIGHT; left_in = ph_ff[6:0];
                     end
                     SQ_HEIGHT: begin
                        ph_in = {1'b0, acc_n[15:0]} + 17'd1;
                        if (reduced_ff) begin phase_in = SQ_SB3; left_in = 7'd3; end
                        else begin phase_in = SQ_FRAMEID; left_in = 7'd1; end
                     end
                     SQ_FRAMEID: begin
                        if (acc_n != 32'd0) begin phase_in = SQ_FRAMEID_LEN; left_in = 7'd7; end
                        else begin phase_in = SQ_SB3; left_in = 7'd3; end
                     end
                     SQ_FRAMEID_LEN: begin phase_in = SQ_SB3; left_in = 7'd3; end
                     SQ_SB3: begin
                        if (reduced_ff) begin phase_in = SQ_SUPERRES3; left_in = 7'd3; end
                        else begin phase_in = SQ_COMP4; left_in = 7'd4; end
                     end
                     SQ_COMP4: begin phase_in = SQ_ORDER_HINT; left_in = 7'd1; end
                     SQ_ORDER_HINT: begin
                        if (acc_n != 32'd0) begin
                           oh_in = 1'b1; phase_in = SQ_JNT; left_in = 7'd2;
                        end else begin phase_in = SQ_SCT_CHOOSE; left_in = 7'd1; end
                     end
                     SQ_JNT: begin phase_in = SQ_SCT_CHOOSE; left_in = 7'd1; end
                     SQ_SCT_CHOOSE: begin
                        phase_in = (acc_n != 32'd0) ? SQ_IMV_CHOOSE : SQ_SCT_FORCE;
                        left_in  = 7'd1;
                     end
                     SQ_SCT_FORCE: begin
                        if (acc_n != 32'd0) begin phase_in = SQ_IMV_CHOOSE; left_in = 7'd1; end
                        else begin
                           phase_in = oh_ff ? SQ_OH_BITS : SQ_SUPERRES3; left_in = 7'd3;
                        end
                     end
                     SQ_IMV_CHOOSE: begin
                        if (acc_n != 32'd0) begin
                           phase_in = oh_ff ? SQ_OH_BITS : SQ_SUPERRES3; left_in = 7'd3;
                        end else begin phase_in = SQ_IMV_FORCE; left_in = 7'd1; end
                     end
                     SQ_IMV_FORCE: begin
                        phase_in = oh_ff ? SQ_OH_BITS : SQ_SUPERRES3; left_in = 7'd3;
                     end
                     SQ_OH_BITS: begin phase_in = SQ_SUPERRES3; left_in = 7'd3; end
                     SQ_SUPERRES3: begin phase_in = SQ_HIGHBD; left_in = 7'd1; end
                     SQ_HIGHBD: begin
                        hbd_in = hbd_ff | acc_n[0];
                        if (prof_ff == 3'd2 && acc_n[0]) begin
                           phase_in = SQ_TWELVE; left_in = 7'd1;
                        end else if (prof_ff != 3'd1) begin
                           phase_in = SQ_MONO; left_in = 7'd1;
                        end else begin
                           colour_in = colour_code(prof_ff, hbd_ff | acc_n[0], twelve_ff, 1'b0);
                           phase_in  = SQ_DONE; left_in = 7'd0;
                        end
                     end
                     SQ_TWELVE: begin
                        twelve_in = twelve_ff | acc_n[0];
                        if (prof_ff != 3'd1) begin phase_in = SQ_MONO; left_in = 7'd1; end
                        else begin
                           colour_in = colour_code(prof_ff, hbd_ff, twelve_ff | acc_n[0], 1'b0);
                           phase_in  = SQ_DONE; left_in = 7'd0;
                        end
                     end
                     SQ_MONO: begin
                        colour_in = colour_code(prof_ff, hbd_ff, twelve_ff, acc_n[0]);
                        phase_in  = SQ_DONE; left_in = 7'd0;
                     end
                     default: begin phase_in = SQ_DONE; left_in = 7'd0; end
                  endcase
               end
            end
         end
         B_RESULT: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in      = 1'b1;
               ostatus_in = status;
               otype_in   = type_ff;
               oslice_in  = ok && (type_ff inside {ObuFrameHeader, ObuTileGroup, ObuFrame});
               oframes_in = 32'(count_ff);
               if (ok && frame_ff) begin
                  kind_in    = fkind_ff;
                  count_in   = count_ff + FrameCountBits'(1);
                  oframes_in = 32'(count_ff + FrameCountBits'(1));
               end
               if (ok && type_ff == ObuSeqHeader) begin
                  cw_in      = pw_ff;
                  ch_in      = ph_ff;
                  cbits_in   = colour_ff[3:0];
                  cchroma_in = colour_ff[5:4];
               end
               phase_in = PH_HEADER; acc_in = '0; left_in = '0; leb_in = '0;
               lebcnt_in = '0; pay_in = '0; ops_in = '0; prof_in = '0;
               reduced_in = 1'b0; dm_in = 1'b0; idd_in = 1'b0; oh_in = 1'b0;
               hbd_in = 1'b0; twelve_in = 1'b0; size_in = 1'b0; frame_in = 1'b0;
               fkind_in = '0; delay_in = '0; pw_in = '0; ph_in = '0; colour_in = '0;
               st_in = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= B_IDLE; byte_ff <= '0; last_ff <= 1'b0; bit_ff <= '0;
         phase_ff <= PH_HEADER; acc_ff <= '0; left_ff <= '0; leb_ff <= '0;
         lebcnt_ff <= '0; pay_ff <= '0; ops_ff <= '0; prof_ff <= '0;
         reduced_ff <= 1'b0; dm_ff <= 1'b0; idd_ff <= 1'b0; oh_ff <= 1'b0;
         hbd_ff <= 1'b0; twelve_ff <= 1'b0; size_ff <= 1'b0; frame_ff <= 1'b0;
         fkind_ff <= '0; delay_ff <= '0; pw_ff <= '0; ph_ff <= '0; colour_ff <= '0;
         type_ff <= '0; kind_ff <= '0; cw_ff <= '0; ch_ff <= '0; cbits_ff <= '0;
         cchroma_ff <= 2'd1; count_ff <= '0; ov_ff <= 1'b0; ostatus_ff <= '0;
         otype_ff <= '0; oslice_ff <= 1'b0; oframes_ff <= '0;
      end else begin
         st_ff <= st_in; byte_ff <= byte_in; last_ff <= last_in; bit_ff <= bit_in;
         phase_ff <= phase_in; acc_ff <= acc_in; left_ff <= left_in; leb_ff <= leb_in;
         lebcnt_ff <= lebcnt_in; pay_ff <= pay_in; ops_ff <= ops_in; prof_ff <= prof_in;
         reduced_ff <= reduced_in; dm_ff <= dm_in; idd_ff <= idd_in; oh_ff <= oh_in;
         hbd_ff <= hbd_in; twelve_ff <= twelve_in; size_ff <= size_in; frame_ff <= frame_in;
         fkind_ff <= fkind_in; delay_ff <= delay_in; pw_ff <= pw_in; ph_ff <= ph_in;
         colour_ff <= colour_in; type_ff <= type_in; kind_ff <= kind_in; cw_ff <= cw_in;
         ch_ff <= ch_in; cbits_ff <= cbits_in; cchroma_ff <= cchroma_in;
         count_ff <= count_in; ov_ff <= ov_in; ostatus_ff <= ostatus_in;
         otype_ff <= otype_in; oslice_ff <= oslice_in; oframes_ff <= oframes_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/av1_obu_header_parser_unit.sv =====
`default_nettype none
// channel  direction  handshake             payload
// req_     in         req_valid/req_stall   data_byte, last_byte
// rsp_     out        rsp_valid/rsp_stall   status .. frames_seen, one per obu
//
// header, extension, size, frame and skipped payload bytes are handled whole in
// the back end; sequence header payload bytes are walked one syntax bit a cycle
// until the colour bits are read, and whole after that.
// after the final byte of an obu, the result state loads the result register.
// a 2-entry queue takes bytes while the back end walks bits or the result stalls.
// reset is synchronous and clears the parse state; chroma format resets to 4:2:0.
module av1_obu_header_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_obu_type,
   output logic             rsp_is_slice,
   output logic [1:0]       rsp_picture_kind,
   output logic [16:0]      rsp_frame_width,
   output logic [16:0]      rsp_frame_height,
   output logic [3:0]       rsp_sample_bits,
   output logic [1:0]       rsp_chroma_format,
   output logic [31:0]      rsp_frames_seen
);
   import obuhp_pkg::*;

   item_type item;
   logic     item_valid;
   logic     item_pop;

   obuhp_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data_byte, .req_last_byte,
      .item_valid, .item, .item_pop
   );

   obuhp_back u_back (
      .clock, .reset, .item_valid, .item, .item_pop, .rsp_valid, .rsp_stall,
      .rsp_status, .rsp_obu_type, .rsp_is_slice, .rsp_picture_kind,
      .rsp_frame_width, .rsp_frame_height, .rsp_sample_bits, .rsp_chroma_format,
      .rsp_frames_seen
   );

`ifndef NO_ASSERTIONS
   a_slice_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_slice |-> rsp_status == StatusOk &&
         (rsp_obu_type == ObuFrameHeader || rsp_obu_type == ObuTileGroup ||
          rsp_obu_type == ObuFrame))
      else $error("slice flag on a bad or non-frame obu");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("pop from empty queue");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_bits != 4'd0 |->
         rsp_sample_bits == 4'd8 || rsp_sample_bits == 4'd10 || rsp_sample_bits == 4'd12)
      else $error("bad sample depth");
`endif

endmodule
`default_nettype wire
